[hdl/tcm_pkg.sv]
package tcm_pkg;

  // Width of the extent and screen registers and of the held point
  localparam int REG_BITS = 12;
  localparam int RAW_BITS = 16;
  // Clamped raw value before rescale: non-negative part of a 16-bit signed value
  localparam int AXIS_BITS = RAW_BITS - 1;
  // Rotated coordinate, signed, wide enough for panel - 1 - axis value
  localparam int POS_BITS = AXIS_BITS + 2;
  // Rescale numerator: value * (panel - 1) + rounding term
  localparam int PROD_BITS = 2 * REG_BITS;
  // Quotient bits produced by the divider, one per step
  localparam int DIV_STEPS = REG_BITS;
  localparam int ROT_BITS = 2;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_RAW_W = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAW_H = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PNL_W = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PNL_H = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCR_W = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCR_H = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT   = 3'd6;

  localparam logic [REG_BITS-1:0] RAW_W_RST = 12'd480;
  localparam logic [REG_BITS-1:0] RAW_H_RST = 12'd800;
  localparam logic [REG_BITS-1:0] PNL_W_RST = 12'd480;
  localparam logic [REG_BITS-1:0] PNL_H_RST = 12'd800;

  localparam logic [ROT_BITS-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_BITS-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_BITS-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_BITS-1:0] ROT_270 = 2'd3;

endpackage

[hdl/touch_coordinate_mapper_top.sv]
// Touch coordinate mapper.
// Input channel (in_valid/in_ready): one touch poll per transfer, carrying
// touched, raw_x and raw_y. Output channel (out_valid/out_ready): pressed and
// the screen point, at most one result per poll. Configuration is written
// through cfg_wen/cfg_idx/cfg_data; the user must write it only while the
// block is idle; the block itself does not enforce this. A touched poll
// walks both axes through one shared 12-step restoring divider: per axis a
// clamp/multiply step, a divider start, 12 divide steps and the done flag,
// then a rotate/clamp step and an output load. An axis that needs no rescale
// skips the divider; a release poll goes straight to the output load. One
// poll is in flight at a time, and the next poll is taken only once the
// result is loaded.
// Polls while screen width or height is zero are dropped with no result.
// Reset restores the register defaults and clears the held point to zero.
// A stalled receiver holds the result in the output register; the next poll
// is still taken and worked on, and waits for the output register before its
// result is loaded.
module touch_coordinate_mapper_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                touched,
  input  logic signed [tcm_pkg::RAW_BITS-1:0] raw_x,
  input  logic signed [tcm_pkg::RAW_BITS-1:0] raw_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                pressed,
  output logic [COORD_BITS-1:0]               point_x,
  output logic [COORD_BITS-1:0]               point_y,
  input  logic                                cfg_wen,
  input  logic [tcm_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [tcm_pkg::REG_BITS-1:0]        cfg_data
);

  localparam int RB = tcm_pkg::REG_BITS;
  localparam int AB = tcm_pkg::AXIS_BITS;
  localparam int PB = tcm_pkg::POS_BITS;
  localparam int MB = tcm_pkg::PROD_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AXIS = 3'd1;
  localparam logic [2:0] ST_DIVS = 3'd2;
  localparam logic [2:0] ST_DIVW = 3'd3;
  localparam logic [2:0] ST_ROT  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [RB-1:0] raw_w, raw_h, pnl_w, pnl_h, scr_w, scr_h;
  logic [tcm_pkg::ROT_BITS-1:0] rot;
  logic [RB-1:0] held_x, held_y;
  logic [2:0]    state;
  logic          ax;
  logic          t_touched;
  logic signed [tcm_pkg::RAW_BITS-1:0] t_rx, t_ry;
  logic [AB-1:0] px, py;
  logic [MB-1:0] prod;

  logic                                raw_sel;
  logic signed [tcm_pkg::RAW_BITS-1:0] raw_cur;
  logic [RB-1:0] rext, pext, rext_m1;
  logic [AB-1:0] vclamp;
  logic          do_scale;
  logic [MB-1:0] prod_next;
  logic          scr_zero;
  logic          div_start, div_done;
  logic [RB-1:0] div_q;
  logic signed [PB-1:0] pxs, pys, pwm, phm, rx_pos, ry_pos;
  logic [RB-1:0] cx, cy;
  logic          out_load;

  function automatic logic [RB-1:0] clamp_scr(input logic signed [PB-1:0] v,
                                               input logic [RB-1:0] size);
    logic [RB-1:0] r;
    if (v[PB-1]) begin
      r = '0;
    end else if (v[PB-2:0] >= (PB-1)'(size)) begin
      r = size - RB'(1);
    end else begin
      r = v[RB-1:0];
    end
    return r;
  endfunction

  assign scr_zero  = (scr_w == '0) || (scr_h == '0);
  assign in_ready  = (state == ST_IDLE);
  assign div_start = (state == ST_DIVS);
  assign raw_sel   = ax;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  // Axis front end: clamp, decide on rescale, form the rounded numerator
  always_comb begin
    raw_cur = raw_sel ? t_ry : t_rx;
    rext    = raw_sel ? raw_h : raw_w;
    pext    = raw_sel ? pnl_h : pnl_w;
    rext_m1 = rext - RB'(1);
    vclamp  = raw_cur[tcm_pkg::RAW_BITS-1] ? '0 : raw_cur[AB-1:0];
    if ((rext > RB'(1)) && (vclamp >= AB'(rext))) begin
      vclamp = AB'(rext_m1);
    end
    do_scale  = (rext > RB'(1)) && (pext > RB'(1)) && (rext != pext);
    prod_next = MB'(vclamp[RB-1:0]) * MB'(pext - RB'(1));
    prod_next = prod_next + MB'(rext_m1 >> 1);
  end

  tcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (rext_m1),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    pxs = $signed(PB'(px));
    pys = $signed(PB'(py));
    pwm = $signed(PB'(pnl_w)) - PB'(1);
    phm = $signed(PB'(pnl_h)) - PB'(1);
    case (rot)
      tcm_pkg::ROT_90: begin
        rx_pos = pys;
        ry_pos = pwm - pxs;
      end
      tcm_pkg::ROT_180: begin
        rx_pos = pwm - pxs;
        ry_pos = phm - pys;
      end
      tcm_pkg::ROT_270: begin
        rx_pos = phm - pys;
        ry_pos = pxs;
      end
      default: begin
        rx_pos = pxs;
        ry_pos = pys;
      end
    endcase
    cx = clamp_scr(rx_pos, scr_w);
    cy = clamp_scr(ry_pos, scr_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_w <= tcm_pkg::RAW_W_RST;
      raw_h <= tcm_pkg::RAW_H_RST;
      pnl_w <= tcm_pkg::PNL_W_RST;
      pnl_h <= tcm_pkg::PNL_H_RST;
      scr_w <= '0;
      scr_h <= '0;
      rot   <= tcm_pkg::ROT_0;
    end else if (cfg_wen) begin
      case (cfg_idx)
        tcm_pkg::REG_RAW_W: raw_w <= cfg_data;
        tcm_pkg::REG_RAW_H: raw_h <= cfg_data;
        tcm_pkg::REG_PNL_W: pnl_w <= cfg_data;
        tcm_pkg::REG_PNL_H: pnl_h <= cfg_data;
        tcm_pkg::REG_SCR_W: scr_w <= cfg_data;
        tcm_pkg::REG_SCR_H: scr_h <= cfg_data;
        tcm_pkg::REG_ROT:   rot   <= cfg_data[tcm_pkg::ROT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ax        <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            t_touched <= touched;
            t_rx      <= raw_x;
            t_ry      <= raw_y;
            ax        <= 1'b0;
            // drop polls while the screen is disabled
            if (!scr_zero) begin
              state <= touched ? ST_AXIS : ST_OUT;
            end
          end
        end
        ST_AXIS: begin
          prod <= prod_next;
          if (do_scale) begin
            state <= ST_DIVS;
          end else begin
            if (ax) begin
              py    <= vclamp;
              state <= ST_ROT;
            end else begin
              px    <= vclamp;
              ax    <= 1'b1;
            end
          end
        end
        ST_DIVS: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            if (ax) begin
              py    <= AB'(div_q);
              state <= ST_ROT;
            end else begin
              px    <= AB'(div_q);
              ax    <= 1'b1;
              state <= ST_AXIS;
            end
          end
        end
        ST_ROT: begin
          held_x <= cx;
          held_y <= cy;
          state  <= ST_OUT;
        end
        ST_OUT: begin
          // wait for the output register to free up
          if (out_load) begin
            pressed <= t_touched;
            point_x <= COORD_BITS'(held_x);
            point_y <= COORD_BITS'(held_y);
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVW))
    else $error("divider finished outside the wait state");

  a_drop_disabled: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && scr_zero) |=> (state == ST_IDLE))
    else $error("poll taken while screen disabled");

  a_held_in_screen: assert property (@(posedge clk) disable iff (rst)
    $past(state == ST_ROT) |-> (held_x < scr_w) && (held_y < scr_h))
    else $error("held point outside screen");

  a_quot_in_panel: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_q <= pext - RB'(1)))
    else $error("rescale quotient beyond panel extent");

endmodule

[hdl/tcm_div.sv]
module tcm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tcm_pkg::PROD_BITS-1:0] dividend,
  input  logic [tcm_pkg::REG_BITS-1:0]  divisor,
  output logic                          done,
  output logic [tcm_pkg::REG_BITS-1:0]  quot
);

  localparam int RB = tcm_pkg::REG_BITS;
  localparam int CNT_BITS = $clog2(tcm_pkg::DIV_STEPS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [RB-1:0]       rem;
  logic [RB-1:0]       low;
  logic [RB:0]         trial;
  logic [RB:0]         diff;
  logic                ge;
  logic [RB-1:0]       rem_next;

  // Restoring division, one quotient bit per step. The caller guarantees
  // dividend < divisor * 2^REG_BITS, so the upper half starts below the divisor.
  always_comb begin
    trial    = {rem, low[RB-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? diff[RB-1:0] : trial[RB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(tcm_pkg::DIV_STEPS);
        rem <= dividend[tcm_pkg::PROD_BITS-1 -: RB];
        low <= dividend[RB-1:0];
      end else if (cnt != '0) begin
        cnt  <= cnt - CNT_BITS'(1);
        rem  <= rem_next;
        low  <= {low[RB-2:0], 1'b0};
        quot <= {quot[RB-2:0], ge};
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[dv/tb_touch_coordinate_mapper_top.sv]
module tb_touch_coordinate_mapper_top;

  localparam int COORD_BITS = 12;
  localparam int REG_BITS = tcm_pkg::REG_BITS;
  localparam int RAW_BITS = tcm_pkg::RAW_BITS;
  localparam int ROT_BITS = tcm_pkg::ROT_BITS;
  localparam int IDX_BITS = tcm_pkg::CFG_IDX_BITS;
  localparam int MAX_GAP = 17;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 14;
  localparam int POLLS_PER_PHASE = 125;
  localparam int CYCLE_LIMIT = 500000;
  // Index past the end of the register file; writes to it must be ignored
  localparam logic [IDX_BITS-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic                  pressed;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } touch_point_t;

  typedef struct {
    logic [IDX_BITS-1:0] idx;
    logic [REG_BITS-1:0] data;
  } reg_write_t;

  class point_checker;
    logic [REG_BITS-1:0] raw_w = tcm_pkg::RAW_W_RST;
    logic [REG_BITS-1:0] raw_h = tcm_pkg::RAW_H_RST;
    logic [REG_BITS-1:0] pnl_w = tcm_pkg::PNL_W_RST;
    logic [REG_BITS-1:0] pnl_h = tcm_pkg::PNL_H_RST;
    logic [REG_BITS-1:0] scr_w = '0;
    logic [REG_BITS-1:0] scr_h = '0;
    logic [ROT_BITS-1:0] rot = tcm_pkg::ROT_0;
    logic [REG_BITS-1:0] held_x = '0;
    logic [REG_BITS-1:0] held_y = '0;
    touch_point_t expected_points[$];
    int errors = 0;

    function void set_reg(logic [IDX_BITS-1:0] idx, logic [REG_BITS-1:0] data);
      case (idx)
        tcm_pkg::REG_RAW_W: raw_w = data;
        tcm_pkg::REG_RAW_H: raw_h = data;
        tcm_pkg::REG_PNL_W: pnl_w = data;
        tcm_pkg::REG_PNL_H: pnl_h = data;
        tcm_pkg::REG_SCR_W: scr_w = data;
        tcm_pkg::REG_SCR_H: scr_h = data;
        tcm_pkg::REG_ROT:   rot = data[ROT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int scale_axis(logic signed [RAW_BITS-1:0] raw, int rext, int pext);
      int v;
      v = int'(raw);
      if (v < 0) v = 0;
      if (rext > 1 && v >= rext) v = rext - 1;
      if (rext > 1 && pext > 1 && rext != pext)
        v = (v * (pext - 1) + (rext - 1) / 2) / (rext - 1);
      return v;
    endfunction

    function int clamp_to(int v, int size);
      if (v < 0) return 0;
      if (v >= size) return size - 1;
      return v;
    endfunction

    function void note_poll(logic touch, logic signed [RAW_BITS-1:0] rx,
                            logic signed [RAW_BITS-1:0] ry);
      int px, py, pw, ph, x, y;
      touch_point_t pt;
      // polls are dropped while the screen has no area
      if (scr_w == '0 || scr_h == '0) return;
      if (touch) begin
        px = scale_axis(rx, int'(raw_w), int'(pnl_w));
        py = scale_axis(ry, int'(raw_h), int'(pnl_h));
        pw = int'(pnl_w);
        ph = int'(pnl_h);
        case (rot)
          tcm_pkg::ROT_90: begin
            x = py;
            y = pw - 1 - px;
          end
          tcm_pkg::ROT_180: begin
            x = pw - 1 - px;
            y = ph - 1 - py;
          end
          tcm_pkg::ROT_270: begin
            x = ph - 1 - py;
            y = px;
          end
          default: begin
            x = px;
            y = py;
          end
        endcase
        held_x = REG_BITS'(clamp_to(x, int'(scr_w)));
        held_y = REG_BITS'(clamp_to(y, int'(scr_h)));
      end
      pt.pressed = touch;
      pt.x = COORD_BITS'(held_x);
      pt.y = COORD_BITS'(held_y);
      expected_points.push_back(pt);
    endfunction

    function void check_point(logic p, logic [COORD_BITS-1:0] sx,
                              logic [COORD_BITS-1:0] sy);
      touch_point_t e;
      if (expected_points.size() == 0) begin
        $error("result with no poll outstanding: pressed %0d x %0d y %0d", p, sx, sy);
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (p !== e.pressed) begin
        $error("pressed: expected %0d, got %0d", e.pressed, p);
        errors++;
      end
      if (sx !== e.x) begin
        $error("point_x: expected %0d, got %0d", e.x, sx);
        errors++;
      end
      if (sy !== e.y) begin
        $error("point_y: expected %0d, got %0d", e.y, sy);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic touched = 1'b0;
  logic signed [RAW_BITS-1:0] raw_x = '0;
  logic signed [RAW_BITS-1:0] raw_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pressed;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic cfg_wen = 1'b0;
  logic [IDX_BITS-1:0] cfg_idx = '0;
  logic [REG_BITS-1:0] cfg_data = '0;

  point_checker sb = new();
  reg_write_t write_q[$];
  bit burst_in = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  touch_coordinate_mapper_top #(.COORD_BITS(COORD_BITS)) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .touched  (touched),
    .raw_x    (raw_x),
    .raw_y    (raw_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pressed  (pressed),
    .point_x  (point_x),
    .point_y  (point_y),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && cfg_wen) sb.set_reg(cfg_idx, cfg_data);
    if (!rst && out_valid && out_ready) sb.check_point(pressed, point_x, point_y);
    if (!rst && in_valid && in_ready) sb.note_poll(touched, raw_x, raw_y);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Returns right after the edge at which the poll transferred; valid stays up.
  task automatic send_poll(input logic touch, input logic signed [RAW_BITS-1:0] rx,
                           input logic signed [RAW_BITS-1:0] ry);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    touched <= touch;
    raw_x <= rx;
    raw_y <= ry;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_results(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // dropped polls leave no result to wait for; let the datapath empty out
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_write(input logic [IDX_BITS-1:0] reg_idx,
                                      input logic [REG_BITS-1:0] value);
    reg_write_t w;
    w.idx = reg_idx;
    w.data = value;
    write_q.push_back(w);
  endfunction

  task automatic apply_writes();
    reg_write_t w;
    wait_results(1'b1);
    while (write_q.size() > 0) begin
      w = write_q.pop_front();
      cfg_wen <= 1'b1;
      cfg_idx <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  task automatic program_all(input logic [REG_BITS-1:0] rw, input logic [REG_BITS-1:0] rh,
                             input logic [REG_BITS-1:0] pw, input logic [REG_BITS-1:0] ph,
                             input logic [REG_BITS-1:0] sw, input logic [REG_BITS-1:0] sh,
                             input logic [REG_BITS-1:0] rot);
    queue_write(tcm_pkg::REG_RAW_W, rw);
    queue_write(tcm_pkg::REG_RAW_H, rh);
    queue_write(tcm_pkg::REG_PNL_W, pw);
    queue_write(tcm_pkg::REG_PNL_H, ph);
    queue_write(tcm_pkg::REG_SCR_W, sw);
    queue_write(tcm_pkg::REG_SCR_H, sh);
    queue_write(tcm_pkg::REG_ROT, rot);
    apply_writes();
  endtask

  function automatic int pick_extent();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 4095;
      default: return $urandom_range(2, 4095);
    endcase
  endfunction

  // Mostly in-range coordinates, with edges and full 16-bit noise mixed in
  function automatic logic signed [RAW_BITS-1:0] pick_raw(input int ext);
    case ($urandom_range(0, 9))
      0: return RAW_BITS'($urandom);
      1: return RAW_BITS'(ext - 1);
      2: return RAW_BITS'(ext);
      3: return '0;
      4: return '1;
      default: return (ext > 1) ? RAW_BITS'($urandom_range(0, ext - 1))
                                : RAW_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin : stimulus
    logic [ROT_BITS-1:0] rots[4];
    int rw, rh, pw, ph, sw, sh, count;
    rots = '{tcm_pkg::ROT_0, tcm_pkg::ROT_90, tcm_pkg::ROT_180, tcm_pkg::ROT_270};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // screen size is zero out of reset: these polls must vanish
    repeat (3) send_poll(1'($urandom_range(0, 1)), RAW_BITS'($urandom),
                         RAW_BITS'($urandom));

    // keep extent defaults from reset, open a square screen
    queue_write(tcm_pkg::REG_SCR_W, 12'd800);
    queue_write(tcm_pkg::REG_SCR_H, 12'd800);
    apply_writes();
    send_poll(1'b0, '0, '0);
    send_poll(1'b1, 16'sh8000, 16'sh8000);
    send_poll(1'b1, 16'sh7FFF, 16'sh7FFF);
    send_poll(1'b1, 16'sd479, 16'sd799);
    send_poll(1'b1, 16'sd240, 16'sd400);
    send_poll(1'b0, 16'sh7FFF, 16'sh8000);

    // each rotation, with junk in the upper rotation bits
    foreach (rots[i]) begin
      program_all(12'd1024, 12'd600, 12'd480, 12'd800, 12'd640, 12'd900,
                  {10'h3FF, rots[i]});
      send_poll(1'b1, 16'sd1023, 16'sd599);
      send_poll(1'b1, 16'sd300, 16'sd37);
    end

    // degenerate raw and panel extents
    program_all(12'd0, 12'd1, 12'd1, 12'd0, 12'd4095, 12'd4095,
                {10'h000, tcm_pkg::ROT_90});
    send_poll(1'b1, 16'sd5000, 16'sd3000);
    send_poll(1'b1, -16'sd5, 16'sh7FFF);

    queue_write(REG_NONE, 12'hFFF);
    queue_write(tcm_pkg::REG_SCR_W, 12'd1);
    queue_write(tcm_pkg::REG_SCR_H, 12'd1);
    apply_writes();
    send_poll(1'b1, 16'sd100, 16'sd100);

    // closing the screen mid-run must not disturb the held point
    queue_write(tcm_pkg::REG_SCR_W, 12'd0);
    apply_writes();
    send_poll(1'b1, 16'sd50, 16'sd50);
    queue_write(tcm_pkg::REG_SCR_W, 12'd4095);
    apply_writes();
    send_poll(1'b0, '0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      rw = pick_extent();
      rh = pick_extent();
      pw = pick_extent();
      ph = pick_extent();
      sw = $urandom_range(1, 4095);
      sh = $urandom_range(1, 4095);
      if (phase == 0) begin
        rw = 4095; rh = 4095; pw = 2; ph = 4095; sw = 4095; sh = 4095;
      end else if (phase == 1) begin
        rw = 2; rh = 4095; pw = 4095; ph = 1; sw = 1; sh = 4095;
      end else if (phase == 6) begin
        sh = 0;
      end
      if ($urandom_range(0, 1)) queue_write(REG_NONE, REG_BITS'($urandom));
      program_all(REG_BITS'(rw), REG_BITS'(rh), REG_BITS'(pw), REG_BITS'(ph),
                  REG_BITS'(sw), REG_BITS'(sh), REG_BITS'($urandom));

      burst_in = (phase % 4 == 1);
      rx_steady = (phase % 4 == 2);
      if (phase == 3) begin
        // stall the output while polls keep coming so the input backs up
        burst_in = 1'b1;
        hold_req = 1'b1;
      end
      count = (sw == 0 || sh == 0) ? 20 : POLLS_PER_PHASE;
      for (int n = 0; n < count; n++) begin
        if (phase % 3 == 0 && n == count / 2) wait_results(1'b0);
        send_poll($urandom_range(0, 4) != 0, pick_raw(rw), pick_raw(rh));
      end
    end

    wait_results(1'b1);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[touch_coordinate_mapper_top.f]
hdl/tcm_pkg.sv
hdl/tcm_div.sv
hdl/touch_coordinate_mapper_top.sv
dv/tb_touch_coordinate_mapper_top.sv
